// File: design/atu_pkg.sv
package atu_pkg;

    // default table depth
    localparam int ATU_ENTRIES = 8;

    // field widths
    localparam int ADDR_W   = 64;
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 2;

    // window ram word: {size, target, base}
    localparam int WORD_W = 3 * ADDR_W;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_H2D   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_D2H   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW_BASE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MAP,
        S_FIN
    } t_atu_state;

endpackage

// File: design/atu_ram.sv
module atu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/atu_window_translate_top.sv
// Address translation window lookup. A transaction is taken at a clock edge
// with i_start high and o_busy low. A window write or an opcode 3 gives no
// result and does not block; a host-to-device address below the host base
// returns status "below base" in the next cycle, also without blocking. Other
// translations scan the window RAM one entry per cycle through its single
// read port while o_busy is high, and the result appears in the cycle in
// which o_busy falls. Each result appears for exactly one cycle with o_valid;
// it is not held, so the receiver must take it then. i_cfg_we loads the
// host window base and should only be used while no translation is in flight.
module atu_window_translate_top
    import atu_pkg::*;
#(
    parameter int ENTRIES = ATU_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_wdata,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic                i_entry_valid,
    input  logic [ADDR_W-1:0]   i_entry_base,
    input  logic [ADDR_W-1:0]   i_entry_target,
    input  logic [ADDR_W-1:0]   i_entry_size,
    input  logic [ADDR_W-1:0]   i_lookup_addr,
    output logic                o_valid,
    output logic [ADDR_W-1:0]   o_translated_addr,
    output logic [STATUS_W-1:0] o_status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W = IDX_W + 1;
    localparam int CMP_W = (PTR_W > INDEX_W) ? PTR_W : INDEX_W;

    // control state
    t_atu_state          r_state, n_state;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_cptr, n_cptr;
    logic                r_pend, n_pend;
    logic                r_out_vld, n_out_vld;
    logic [ENTRIES-1:0]  r_valid;
    logic [ADDR_W-1:0]   r_host_base;

    // payload
    logic                r_d2h, n_d2h;
    logic [ADDR_W-1:0]   r_key, n_key;
    logic [ADDR_W-1:0]   r_diff, n_diff;
    logic [ADDR_W-1:0]   r_other, n_other;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic                w_accept;
    logic [CMP_W-1:0]    w_idx_ext;
    logic                w_in_range;
    logic                w_ram_we;
    logic [IDX_W-1:0]    w_raddr;
    logic [WORD_W-1:0]   w_rdata;
    logic [ADDR_W-1:0]   w_base, w_target, w_size;
    logic [ADDR_W-1:0]   w_start, w_end, w_far;
    logic                w_hit;
    logic                w_last;
    logic                w_below;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_idx_ext  = CMP_W'(i_entry_index);
    assign w_in_range = w_idx_ext < CMP_W'(ENTRIES);
    assign w_ram_we   = w_accept && (i_opcode == OP_WRITE) && w_in_range;
    assign w_raddr    = r_ptr[IDX_W-1:0];
    assign w_below    = i_lookup_addr < r_host_base;

    atu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx_ext[IDX_W-1:0]),
        .i_wdata ({i_entry_size, i_entry_target, i_entry_base}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // range test on the entry read last cycle
    assign w_base   = w_rdata[ADDR_W-1:0];
    assign w_target = w_rdata[2*ADDR_W-1:ADDR_W];
    assign w_size   = w_rdata[3*ADDR_W-1:2*ADDR_W];
    assign w_start  = r_d2h ? w_target : w_base;
    assign w_far    = r_d2h ? w_base : w_target;
    assign w_end    = w_start + w_size;
    assign w_hit    = r_pend && r_valid[r_cptr] && (w_start <= r_key) && (w_end > r_key);
    assign w_last   = r_cptr == IDX_W'(ENTRIES - 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_D2H)) begin
                    n_state = S_SCAN;
                end else if (w_accept && (i_opcode == OP_H2D) && !w_below) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_MAP;
                end else if (r_pend && w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MAP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_ptr        = r_ptr;
        n_cptr       = r_cptr;
        n_pend       = 1'b0;
        n_out_vld    = 1'b0;
        n_d2h        = r_d2h;
        n_key        = r_key;
        n_diff       = r_diff;
        n_other      = r_other;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (w_accept && (i_opcode == OP_D2H)) begin
                    n_d2h = 1'b1;
                    n_key = i_lookup_addr;
                end else if (w_accept && (i_opcode == OP_H2D)) begin
                    n_d2h = 1'b0;
                    n_key = i_lookup_addr - r_host_base;
                    if (w_below) begin
                        n_out_vld    = 1'b1;
                        n_out_addr   = '0;
                        n_out_status = ST_BELOW_BASE;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while checking the previous one
                if (r_ptr < PTR_W'(ENTRIES)) begin
                    n_pend = 1'b1;
                    n_cptr = w_raddr;
                    n_ptr  = r_ptr + PTR_W'(1);
                end
                if (w_hit) begin
                    n_pend  = 1'b0;
                    n_diff  = r_key - w_start;
                    n_other = w_far;
                end else if (r_pend && w_last) begin
                    n_pend       = 1'b0;
                    n_out_vld    = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_NO_MATCH;
                end
            end
            S_MAP: begin
                n_diff = r_diff + r_other;
            end
            S_FIN: begin
                n_out_vld    = 1'b1;
                n_out_addr   = r_diff + (r_d2h ? r_host_base : '0);
                n_out_status = ST_OK;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cptr      <= '0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_valid     <= '0;
            r_host_base <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cptr    <= n_cptr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (w_ram_we) begin
                r_valid[w_idx_ext[IDX_W-1:0]] <= i_entry_valid;
            end
            if (i_cfg_we) begin
                r_host_base <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_d2h        <= n_d2h;
        r_key        <= n_key;
        r_diff       <= n_diff;
        r_other      <= n_other;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_busy            = r_state != S_IDLE;
    assign o_valid           = r_out_vld;
    assign o_translated_addr = r_out_addr;
    assign o_status          = r_out_status;

endmodule

// File: dv/tb.sv
module tb;
    import atu_pkg::*;

    localparam int ENTRIES = ATU_ENTRIES;
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
    // longest busy stretch plus the result cycle, with margin
    localparam int DRAIN_CYCLES = ENTRIES + 6;
    localparam int PHASE_ITEMS = 205;
    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } xlat_t;

    // shadow of the window table and host base, with the translations still owed
    class atu_shadow;
        bit              win_valid  [ENTRIES];
        bit [ADDR_W-1:0] win_base   [ENTRIES];
        bit [ADDR_W-1:0] win_target [ENTRIES];
        bit [ADDR_W-1:0] win_size   [ENTRIES];
        bit [ADDR_W-1:0] host_base;
        xlat_t           owed_xlat[$];
        int              n_errors;
        int              n_writes;
        int              n_hit;
        int              n_miss;
        int              n_below;

        function new();
            host_base = '0;
            foreach (win_valid[i]) win_valid[i] = 1'b0;
        endfunction

        // first valid window on the given side holding the address wins
        function bit scan_windows(bit from_target, bit [ADDR_W-1:0] a,
                                  output bit [ADDR_W-1:0] mapped);
            bit [ADDR_W-1:0] lo;
            bit [ADDR_W-1:0] hi;
            bit [ADDR_W-1:0] other;
            mapped = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (!win_valid[i]) continue;
                lo    = from_target ? win_target[i] : win_base[i];
                other = from_target ? win_base[i] : win_target[i];
                hi    = lo + win_size[i];
                if (lo <= a && hi > a) begin
                    mapped = a - lo + other;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // accepted transaction: update the table or queue the translation
        function void take_item(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic vld, logic [ADDR_W-1:0] base,
                                logic [ADDR_W-1:0] tgt, logic [ADDR_W-1:0] size,
                                logic [ADDR_W-1:0] a);
            xlat_t           e;
            bit [ADDR_W-1:0] m;
            e = '0;
            case (op)
                OP_WRITE: begin
                    win_valid[idx]  = vld;
                    win_base[idx]   = base;
                    win_target[idx] = tgt;
                    win_size[idx]   = size;
                    n_writes++;
                    return;
                end
                OP_H2D: begin
                    if (a < host_base) begin
                        e.status = ST_BELOW_BASE;
                    end else if (scan_windows(1'b0, a - host_base, m)) begin
                        e.status = ST_OK;
                        e.addr   = m;
                    end else begin
                        e.status = ST_NO_MATCH;
                    end
                end
                OP_D2H: begin
                    if (scan_windows(1'b1, a, m)) begin
                        e.status = ST_OK;
                        e.addr   = m + host_base;
                    end else begin
                        e.status = ST_NO_MATCH;
                    end
                end
                default: return;
            endcase
            owed_xlat.push_back(e);
        endfunction

        task report_mismatch(string msg);
            if (n_errors < MAX_PRINTED) $display("mismatch: %s", msg);
            n_errors++;
        endtask

        task check_result(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] st);
            xlat_t e;
            if (owed_xlat.size() == 0) begin
                report_mismatch($sformatf("unexpected result addr %h status %0d", a, st));
                return;
            end
            e = owed_xlat.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (a !== e.addr)
                report_mismatch($sformatf("addr %h, expected %h", a, e.addr));
            case (e.status)
                ST_OK:       n_hit++;
                ST_NO_MATCH: n_miss++;
                default:     n_below++;
            endcase
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [ADDR_W-1:0]   i_cfg_wdata;
    logic                i_start;
    logic                o_busy;
    logic [OPCODE_W-1:0] i_opcode;
    logic [INDEX_W-1:0]  i_entry_index;
    logic                i_entry_valid;
    logic [ADDR_W-1:0]   i_entry_base;
    logic [ADDR_W-1:0]   i_entry_target;
    logic [ADDR_W-1:0]   i_entry_size;
    logic [ADDR_W-1:0]   i_lookup_addr;
    logic                o_valid;
    logic [ADDR_W-1:0]   o_translated_addr;
    logic [STATUS_W-1:0] o_status;

    atu_shadow sb;
    int        n_settings;

    atu_window_translate_top #(.ENTRIES(ENTRIES)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_opcode          (i_opcode),
        .i_entry_index     (i_entry_index),
        .i_entry_valid     (i_entry_valid),
        .i_entry_base      (i_entry_base),
        .i_entry_target    (i_entry_target),
        .i_entry_size      (i_entry_size),
        .i_lookup_addr     (i_lookup_addr),
        .o_valid           (o_valid),
        .o_translated_addr (o_translated_addr),
        .o_status          (o_status)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result check first, then note a transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) sb.check_result(o_translated_addr, o_status);
            if (i_start === 1'b1 && o_busy === 1'b0)
                sb.take_item(i_opcode, i_entry_index, i_entry_valid, i_entry_base,
                             i_entry_target, i_entry_size, i_lookup_addr);
        end
    end

    function automatic bit [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // window sizes: empty, one byte, full range, random 64-bit, mid, small
    function automatic bit [ADDR_W-1:0] rand_span();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2: return '1;
            3: return rand64();
            4: return 64'($urandom);
            default: return 64'($urandom_range(1, 4096));
        endcase
    endfunction

    // window starts cluster low and high so windows overlap
    function automatic bit [ADDR_W-1:0] rand_start();
        case ($urandom_range(0, 3))
            0: return rand64();
            3: return 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
            default: return (64'($urandom_range(0, 3)) << 12) + 64'($urandom_range(0, 255));
        endcase
    endfunction

    // address aimed at one side of a table entry: inside, at the edges or off
    function automatic bit [ADDR_W-1:0] pick_addr(bit target_side);
        int              k;
        bit [ADDR_W-1:0] lo;
        bit [ADDR_W-1:0] sz;
        k  = $urandom_range(0, ENTRIES - 1);
        lo = target_side ? sb.win_target[k] : sb.win_base[k];
        sz = sb.win_size[k];
        case ($urandom_range(0, 9))
            0: return rand64();
            1: return lo;
            2: return lo + sz - 1;
            3: return lo + sz;
            4: return lo - 1;
            default: return (sz == 0) ? lo : lo + (rand64() % sz);
        endcase
    endfunction

    // present one transaction and hold it until taken
    task send_xact(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx, logic vld,
                   logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] tgt,
                   logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] a);
        i_start        <= 1'b1;
        i_opcode       <= op;
        i_entry_index  <= idx;
        i_entry_valid  <= vld;
        i_entry_base   <= base;
        i_entry_target <= tgt;
        i_entry_size   <= size;
        i_lookup_addr  <= a;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    task put_window(int idx, logic vld, logic [ADDR_W-1:0] base,
                    logic [ADDR_W-1:0] tgt, logic [ADDR_W-1:0] size);
        send_xact(OP_WRITE, INDEX_W'(idx), vld, base, tgt, size, rand64());
    endtask

    task h2d(logic [ADDR_W-1:0] a);
        send_xact(OP_H2D, INDEX_W'($urandom), 1'($urandom), rand64(), rand64(),
                  rand64(), a);
    endtask

    task d2h(logic [ADDR_W-1:0] a);
        send_xact(OP_D2H, INDEX_W'($urandom), 1'($urandom), rand64(), rand64(),
                  rand64(), a);
    endtask

    task pause_sender(int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending until every owed translation is back and the block is quiet
    task drain_pending();
        i_start <= 1'b0;
        while (sb.owed_xlat.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_host_base(logic [ADDR_W-1:0] v);
        drain_pending();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.host_base = v;
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // mostly aimed lookups, some window writes, a few reserved opcodes
    task random_item(bit calm);
        int              r;
        bit [ADDR_W-1:0] a;
        if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 14));
        r = $urandom_range(0, 99);
        if (r < 18) begin
            put_window($urandom_range(0, ENTRIES - 1), $urandom_range(0, 3) != 0,
                       rand_start(), rand_start(), rand_span());
        end else if (r < 20) begin
            send_xact(OP_RESERVED, INDEX_W'($urandom), 1'($urandom), rand64(),
                      rand64(), rand64(), rand64());
        end else if (r < 60) begin
            a = pick_addr(1'b0) + sb.host_base;
            if ($urandom_range(0, 9) == 0) a = sb.host_base - 64'($urandom_range(1, 300));
            h2d(a);
        end else begin
            d2h(pick_addr(1'b1));
        end
    endtask

    // stimulus
    initial begin
        bit [ADDR_W-1:0] bases [7];
        bit              calm;
        sb = new();
        n_settings = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_start        <= 1'b0;
        i_opcode       <= OP_WRITE;
        i_entry_index  <= '0;
        i_entry_valid  <= 1'b0;
        i_entry_base   <= '0;
        i_entry_target <= '0;
        i_entry_size   <= '0;
        i_lookup_addr  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load every entry invalid so no lookup reads an unwritten window
        for (int k = 0; k < ENTRIES; k++)
            put_window(k, 1'b0, 64'(k) << 12, 64'h8000_0000 + (64'(k) << 12), 64'h1000);
        h2d(64'h0);
        d2h('1);
        // target range ending exactly at the top wraps and never matches
        put_window(7, 1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 64'h1000);
        h2d(64'h10);
        d2h(64'hFFFF_FFFF_FFFF_F010);
        // lower index wins on overlap
        put_window(3, 1'b1, 64'h0, 64'h4000, 64'h100);
        h2d(64'h10);
        // empty window matches nothing
        put_window(0, 1'b1, 64'h10, 64'h9000, 64'h0);
        h2d(64'h10);
        // window just under the top of the address space
        put_window(5, 1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 64'hFF);
        h2d(64'hFFFF_FFFF_FFFF_FFFE);
        h2d('1);
        d2h(64'hFE);
        send_xact(OP_RESERVED, '1, 1'b1, '1, '1, '1, '1);
        // nonzero host base: below base, offset lookup, base added back
        write_host_base(64'h1000);
        h2d(64'h0FFF);
        h2d(64'h1010);
        d2h(64'h4010);

        bases[0] = '0;
        bases[1] = '1;
        bases[2] = rand64();
        bases[3] = 64'($urandom_range(1, 4096));
        bases[4] = 64'h8000_0000_0000_0000;
        bases[5] = rand64();
        bases[6] = '0;
        calm = 1'b0;
        for (int p = 0; p < 7; p++) begin
            write_host_base(bases[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 59) == 0) calm = !calm;
                if (p != 6 && $urandom_range(0, 149) == 0) drain_pending();
                random_item(calm || p == 6);
            end
        end

        drain_pending();
        if (sb.owed_xlat.size() != 0)
            sb.report_mismatch($sformatf("%0d translations never returned",
                                         sb.owed_xlat.size()));
        $display("run covered %0d window writes and %0d translations over %0d host bases",
                 sb.n_writes, sb.n_hit + sb.n_miss + sb.n_below, n_settings);
        $display("translations: %0d hit, %0d no window, %0d below base",
                 sb.n_hit, sb.n_miss, sb.n_below);
        if (sb.n_errors == 0) begin
            $display("[atu_window_translate_top] OK");
        end else begin
            $display("[atu_window_translate_top] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 400000);
        $display("[atu_window_translate_top] ERROR");
        $finish;
    end

endmodule
